### design/page_hotness_tracker_core_macros.svh
// ----------------------------------------------------------------------------
// page hotness tracker assertion macros
// concurrent checks sampled on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef PAGE_HOTNESS_TRACKER_CORE_MACROS_SVH
`define PAGE_HOTNESS_TRACKER_CORE_MACROS_SVH

// antecedent holds, consequent must hold in the cycle after
`define PHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// antecedent holds, consequent must hold in the same cycle
`define PHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### design/pht_pkg.sv
// ----------------------------------------------------------------------------
// pht_pkg
// sizes, codes and the page entry layout of the page hotness tracker
// ----------------------------------------------------------------------------
`default_nettype none

package pht_pkg;

  localparam int PAGES       = 4096;
  localparam int COUNT_WIDTH = 16;
  localparam int EPOCH_WIDTH = 32;

  localparam int PAGE_AW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int SH_W    = $clog2(COUNT_WIDTH);
  localparam int CMP_W   = 34;

  // field widths fixed by the interface
  localparam int OP_W      = 3;
  localparam int PIDX_W    = 12;
  localparam int REQ_W     = 2;
  localparam int EPOCH_OUT_W = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam int IN_W       = OP_W + PIDX_W + 1;
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = 1 + REQ_W + 1 + EPOCH_OUT_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // event codes
  localparam logic [OP_W-1:0] OP_SAMPLE  = 3'd0;
  localparam logic [OP_W-1:0] OP_PROMOTE = 3'd1;
  localparam logic [OP_W-1:0] OP_DEMOTE  = 3'd2;
  localparam logic [OP_W-1:0] OP_MAP     = 3'd3;
  localparam logic [OP_W-1:0] OP_UNMAP   = 3'd4;

  // request codes
  localparam logic [REQ_W-1:0] REQ_NONE    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PROMOTE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DEMOTE  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HOT_THR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COOL_THR = 1'd1;

  localparam logic [CFG_W-1:0] HOT_THR_RST  = 16'd8;
  localparam logic [CFG_W-1:0] COOL_THR_RST = 16'd18;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic                   mapped;
    logic                   pending;
    logic                   hot;
    logic [EPOCH_WIDTH-1:0] page_epoch;
    logic [COUNT_WIDTH-1:0] slow_cnt;
    logic [COUNT_WIDTH-1:0] fast_cnt;
  } entry_t;

endpackage

`default_nettype wire

### design/page_hotness_tracker_core.sv
// ----------------------------------------------------------------------------
// page_hotness_tracker_core
// per-page read hotness with epoch decay, promote and demote requests
// ----------------------------------------------------------------------------
// One word in gives one word out. Each page entry (two saturating read
// counters, a last-epoch stamp and hot, pending and mapped bits) sits in a
// single-port-write memory with a registered read. The entry is read at the
// edge that accepts the input word, then modified and written back in
// S_CALC, which also loads the result register once that register is free
// or its result is taken. in_tready stays low until the write-back, so no
// word is accepted before the last one is through. The result register
// lets the next word be accepted while a finished result still waits on
// out_tready. After reset the block sweeps all PAGES entries (4096 here)
// to zero, one entry per cycle, and keeps in_tready low until done;
// configuration writes are taken at any time but are meant for idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

`include "page_hotness_tracker_core_macros.svh"

module page_hotness_tracker_core
  import pht_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // operation, page_index, source_tier
  // result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // status, request, epoch_advanced, epoch
  // configuration writes
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC
  } state_t;

  state_t                 state_r;
  logic [PAGE_AW-1:0]     clr_addr_r;
  logic [CFG_W-1:0]       hot_thr_r;
  logic [CFG_W-1:0]       cool_thr_r;
  logic [EPOCH_WIDTH-1:0] global_epoch_r;
  logic [EPOCH_WIDTH-1:0] global_epoch_nxt;

  // latched event
  logic [OP_W-1:0]        op_r;
  logic [PAGE_AW-1:0]     addr_r;
  logic                   tier_r;
  logic                   range_r;

  logic                   out_valid_r;
  logic [OUT_W-1:0]       out_data_r;

  // entry memory
  entry_t                 mem [PAGES];
  entry_t                 rd_entry_r;
  entry_t                 entry_nxt;
  logic                   mem_we;
  logic [PAGE_AW-1:0]     mem_waddr;
  entry_t                 mem_wdata;

  // input word fields
  logic [OP_W-1:0]        in_op;
  logic [PIDX_W-1:0]      in_page;
  logic                   in_tier;
  logic [PAGE_AW-1:0]     in_addr;
  logic                   in_range;
  logic                   in_fire;

  assign in_op    = in_tdata[OP_W-1:0];
  assign in_page  = in_tdata[OP_W+PIDX_W-1:OP_W];
  assign in_tier  = in_tdata[OP_W+PIDX_W];
  assign in_addr  = PAGE_AW'(32'(in_page));
  assign in_range = 32'(in_page) < 32'(PAGES);

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // result register free or draining this cycle
  logic calc_go;
  assign calc_go = (state_r == S_CALC) && (!out_valid_r || out_tready);

  // sample path: bump, threshold check, decay, cooling check
  logic [COUNT_WIDTH-1:0] cnt_old;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [COUNT_WIDTH-1:0] fast_inc;
  logic [COUNT_WIDTH-1:0] slow_inc;
  logic [COUNT_WIDTH:0]   cnt_sum;
  logic                   is_hot;
  logic [EPOCH_WIDTH-1:0] gap;
  logic                   gap_big;
  logic [SH_W-1:0]        shamt;
  logic [COUNT_WIDTH-1:0] fast_dec;
  logic [COUNT_WIDTH-1:0] slow_dec;
  logic [COUNT_WIDTH-1:0] cnt_dec;
  logic                   do_cool;

  always_comb begin
    cnt_old  = tier_r ? rd_entry_r.slow_cnt : rd_entry_r.fast_cnt;
    cnt_inc  = (cnt_old == COUNT_MAX) ? cnt_old : cnt_old + COUNT_WIDTH'(1);
    fast_inc = tier_r ? rd_entry_r.fast_cnt : cnt_inc;
    slow_inc = tier_r ? cnt_inc : rd_entry_r.slow_cnt;
    cnt_sum  = {1'b0, fast_inc} + {1'b0, slow_inc};
    is_hot   = CMP_W'(cnt_sum) >= CMP_W'(hot_thr_r);
    // gap wraps with the epoch
    gap      = global_epoch_r - rd_entry_r.page_epoch;
    gap_big  = gap >= EPOCH_WIDTH'(COUNT_WIDTH);
    shamt    = gap[SH_W-1:0];
    fast_dec = gap_big ? '0 : (fast_inc >> shamt);
    slow_dec = gap_big ? '0 : (slow_inc >> shamt);
    cnt_dec  = tier_r ? slow_dec : fast_dec;
    do_cool  = CMP_W'(cnt_dec) > CMP_W'(cool_thr_r);
  end

  logic             status_nxt;
  logic [REQ_W-1:0] request_nxt;
  logic             adv_nxt;
  logic             calc_we;

  always_comb begin
    entry_nxt        = rd_entry_r;
    status_nxt       = 1'b0;
    request_nxt      = REQ_NONE;
    adv_nxt          = 1'b0;
    global_epoch_nxt = global_epoch_r;
    calc_we          = 1'b0;
    if (op_r > OP_UNMAP) begin
      // unknown code: ignored, status applied
    end else if (!range_r) begin
      status_nxt = 1'b1;
    end else begin
      calc_we = 1'b1;
      unique case (op_r)
        OP_MAP: begin
          entry_nxt.mapped = 1'b1;
        end
        OP_UNMAP: begin
          entry_nxt            = '0;
          entry_nxt.page_epoch = global_epoch_r;
        end
        OP_PROMOTE: begin
          if (!rd_entry_r.mapped) begin
            status_nxt = 1'b1;
          end else begin
            entry_nxt.pending = 1'b0;
            entry_nxt.hot     = 1'b1;
          end
        end
        OP_DEMOTE: begin
          if (!rd_entry_r.mapped) begin
            status_nxt = 1'b1;
          end else begin
            entry_nxt.pending = 1'b0;
            entry_nxt.hot     = 1'b0;
          end
        end
        OP_SAMPLE: begin
          if (!rd_entry_r.mapped) begin
            status_nxt = 1'b1;
          end else begin
            if (is_hot) begin
              if (!rd_entry_r.hot && !rd_entry_r.pending) begin
                entry_nxt.pending = 1'b1;
                request_nxt       = REQ_PROMOTE;
              end
            end else if (rd_entry_r.hot && !rd_entry_r.pending) begin
              entry_nxt.pending = 1'b1;
              request_nxt       = REQ_DEMOTE;
            end
            entry_nxt.fast_cnt   = fast_dec;
            entry_nxt.slow_cnt   = slow_dec;
            entry_nxt.page_epoch = global_epoch_r;
            if (do_cool) begin
              global_epoch_nxt = global_epoch_r + EPOCH_WIDTH'(1);
              adv_nxt          = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // memory write port: clearing sweep or write-back
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = entry_nxt;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else if (calc_go && calc_we) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      rd_entry_r <= mem[in_addr];
    end
  end

  // control, configuration and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_addr_r     <= '0;
      hot_thr_r      <= HOT_THR_RST;
      cool_thr_r     <= COOL_THR_RST;
      global_epoch_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_HOT_THR:  hot_thr_r  <= cfg_data;
          REG_COOL_THR: cool_thr_r <= cfg_data;
          default: begin
          end
        endcase
      end
      // a new result replaces one draining in the same cycle
      if (calc_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + PAGE_AW'(1);
          if (clr_addr_r == PAGE_AW'(PAGES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            op_r    <= in_op;
            addr_r  <= in_addr;
            tier_r  <= in_tier;
            range_r <= in_range;
            state_r <= S_CALC;
          end
        end
        S_CALC: begin
          if (calc_go) begin
            global_epoch_r <= global_epoch_nxt;
            out_data_r     <= {EPOCH_OUT_W'(global_epoch_nxt), adv_nxt,
                               request_nxt, status_nxt};
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

  // an accepted word always goes to the modify-write state
  `PHT_ASSERT_NEXT(a_fire_to_calc, in_fire, state_r == S_CALC, "accepted word did not reach calc")
  // a finishing event loads the result register and frees the input side
  `PHT_ASSERT_NEXT(a_calc_loads_out, calc_go, out_valid_r && state_r == S_IDLE, "result not loaded")
  // the epoch moves only when an event finishes
  `PHT_ASSERT_NEXT(a_epoch_quiet, !calc_go, $stable(global_epoch_r), "epoch moved outside calc")
  // no word is taken during the clearing sweep
  `PHT_ASSERT_NOW(a_no_fire_clear, state_r == S_CLEAR, !in_fire && !calc_go, "activity during clear")

endmodule

`default_nettype wire

### bench/page_hotness_tracker_core_test.sv
// ----------------------------------------------------------------------------
// page_hotness_tracker_core_test
// self-checking bench for the page hotness tracker: a short table of events
// with hand-read results, random event mixes over small mapped page sets
// under several threshold settings, with a back-to-back read run on one page at the
// top thresholds after the first mix, each word checked against its hand-read
// result or against a behavioral tracker
module page_hotness_tracker_core_test;
  import pht_pkg::*;

  // result word layout, status in the lowest bit
  typedef struct packed {
    logic [EPOCH_OUT_W-1:0] epoch;
    logic                   advanced;
    logic [REQ_W-1:0]       request;
    logic                   status;
  } outcome_t;

  // one row of the directed table; want only counts when typed is set
  typedef struct packed {
    logic            typed;
    outcome_t        want;
    logic [OP_W-1:0] op;
    logic [PIDX_W-1:0] page;
    logic            tier;
  } stim_row_t;

  localparam logic ST_APPLIED = 1'b0;
  localparam logic ST_IGNORED = 1'b1;

  // event codes the block ignores
  localparam logic [OP_W-1:0] OP_RESERVED_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_RESERVED_LAST  = 3'd7;

  localparam int STALL_LIMIT   = 12000;  // covers the clearing sweep after reset
  localparam int SETTLE_CYCLES = 8;
  localparam int DIRECTED_ROWS = 20;
  localparam int SHOWN_ERRORS  = 40;
  localparam int RUN_READS     = 40;

  localparam outcome_t IGNORED_AT_ZERO =
    '{epoch: '0, advanced: 1'b0, request: REQ_NONE, status: ST_IGNORED};
  localparam outcome_t APPLIED_AT_ZERO =
    '{epoch: '0, advanced: 1'b0, request: REQ_NONE, status: ST_APPLIED};
  localparam outcome_t NO_OUTCOME = '0;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // operation, page_index, source_tier
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // status, request, epoch_advanced, epoch
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  page_hotness_tracker_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // behavioral page table, mirrors what the block should hold
  // ---------------------------------------------------------------------------
  bit [COUNT_WIDTH-1:0] fast_reads   [PAGES];
  bit [COUNT_WIDTH-1:0] slow_reads   [PAGES];
  bit [EPOCH_WIDTH-1:0] stamp_epoch  [PAGES];
  bit                   page_hot     [PAGES];
  bit                   page_pending [PAGES];
  bit                   page_mapped  [PAGES];
  bit [EPOCH_WIDTH-1:0] cur_epoch;
  bit [CFG_W-1:0]       hot_thr  = HOT_THR_RST;
  bit [CFG_W-1:0]       cool_thr = COOL_THR_RST;

  outcome_t outcome_queue [$];   // results still owed by the block, oldest first

  // bookkeeping
  int mismatches   = 0;
  int events_sent  = 0;
  int results_seen = 0;
  int promotes_seen = 0;
  int demotes_seen  = 0;
  int advances_seen = 0;
  int idle_cycles  = 0;
  int burst_left   = 0;
  bit gaps_on      = 1'b1;
  bit rx_always    = 1'b0;
  int rx_mode      = 0;
  int rx_tick      = 0;
  int run_page     = 0;
  outcome_t got_word, want_word;

  // shift a counter down by the epoch gap, a wide gap clears it
  function automatic bit [COUNT_WIDTH-1:0] decayed(bit [COUNT_WIDTH-1:0] cnt,
                                                   bit [EPOCH_WIDTH-1:0] gap);
    if (gap >= COUNT_WIDTH) return '0;
    return cnt >> gap;
  endfunction

  // apply one event to the page table and return the word the block owes
  function automatic outcome_t track_event(logic [OP_W-1:0] op, logic [PIDX_W-1:0] page,
                                           logic tier);
    outcome_t             res;
    int                   p;
    bit [COUNT_WIDTH-1:0] cnt;
    bit [COUNT_WIDTH:0]   sum;
    bit [EPOCH_WIDTH-1:0] gap;
    res = '0;
    p = int'(page);
    if (op > OP_UNMAP) begin
      // reserved code: nothing changes, status applied
    end else if (p >= PAGES) begin
      res.status = ST_IGNORED;
    end else if (op == OP_MAP) begin
      page_mapped[p] = 1'b1;
    end else if (op == OP_UNMAP) begin
      page_mapped[p]  = 1'b0;
      page_hot[p]     = 1'b0;
      page_pending[p] = 1'b0;
      fast_reads[p]   = '0;
      slow_reads[p]   = '0;
      stamp_epoch[p]  = cur_epoch;
    end else if (!page_mapped[p]) begin
      res.status = ST_IGNORED;
    end else if (op == OP_PROMOTE) begin
      page_pending[p] = 1'b0;
      page_hot[p]     = 1'b1;
    end else if (op == OP_DEMOTE) begin
      page_pending[p] = 1'b0;
      page_hot[p]     = 1'b0;
    end else begin
      // sample: bump the tier counter, saturating
      cnt = tier ? slow_reads[p] : fast_reads[p];
      if (cnt != COUNT_MAX) cnt = cnt + COUNT_WIDTH'(1);
      if (tier) slow_reads[p] = cnt;
      else fast_reads[p] = cnt;
      sum = {1'b0, fast_reads[p]} + {1'b0, slow_reads[p]};
      if (sum >= {1'b0, hot_thr}) begin
        if (!page_hot[p] && !page_pending[p]) begin
          page_pending[p] = 1'b1;
          res.request = REQ_PROMOTE;
        end
      end else if (page_hot[p] && !page_pending[p]) begin
        page_pending[p] = 1'b1;
        res.request = REQ_DEMOTE;
      end
      // age both counters by the epochs missed since the last stamp
      gap = cur_epoch - stamp_epoch[p];
      fast_reads[p]  = decayed(fast_reads[p], gap);
      slow_reads[p]  = decayed(slow_reads[p], gap);
      stamp_epoch[p] = cur_epoch;
      cnt = tier ? slow_reads[p] : fast_reads[p];
      if (cnt > cool_thr) begin
        cur_epoch    = cur_epoch + EPOCH_WIDTH'(1);
        res.advanced = 1'b1;
      end
    end
    res.epoch = cur_epoch[EPOCH_OUT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= SHOWN_ERRORS)
      $display("error @%0t: result %0d %s got %0h want %0h", $time, results_seen, what, got,
               want);
  endtask

  // ---------------------------------------------------------------------------
  // result side: stall pattern, checker and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 256 == 0) rx_mode <= $urandom_range(0, 2);
    if (rx_always || rx_mode == 0) begin
      out_tready <= 1'b1;
    end else if (rx_mode == 1) begin
      out_tready <= ($urandom_range(0, 99) < 60);
    end else begin
      // periodic stall pattern
      out_tready <= (rx_tick % 8 < 3);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_word = out_tdata[OUT_W-1:0];
      if (outcome_queue.size() == 0) begin
        report_mismatch("unexpected word", 64'(out_tdata), '0);
      end else begin
        want_word = outcome_queue.pop_front();
        if (got_word.status !== want_word.status)
          report_mismatch("status", 64'(got_word.status), 64'(want_word.status));
        if (got_word.request !== want_word.request)
          report_mismatch("request", 64'(got_word.request), 64'(want_word.request));
        if (got_word.advanced !== want_word.advanced)
          report_mismatch("epoch_advanced", 64'(got_word.advanced), 64'(want_word.advanced));
        if (got_word.epoch !== want_word.epoch)
          report_mismatch("epoch", 64'(got_word.epoch), 64'(want_word.epoch));
        if (out_tdata[OUT_TDATA_W-1:OUT_W] !== '0)
          report_mismatch("pad bits", 64'(out_tdata[OUT_TDATA_W-1:OUT_W]), '0);
      end
      results_seen++;
      if (got_word.request == REQ_PROMOTE) promotes_seen++;
      if (got_word.request == REQ_DEMOTE) demotes_seen++;
      if (got_word.advanced === 1'b1) advances_seen++;
    end
    // watchdog: no word moving on either side for too long
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles", idle_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // present one event, wait for the handshake and log the owed word;
  // in_tvalid stays high on return so a following event goes out back to back
  task automatic send_event(logic [OP_W-1:0] op, logic [PIDX_W-1:0] page, logic tier,
                            logic typed, outcome_t typed_want);
    logic [IN_TDATA_W-1:0] word;
    outcome_t              predicted;
    int                    gap;
    word = '0;
    word[OP_W-1:0]             = op;
    word[OP_W+PIDX_W-1:OP_W]   = page;
    word[OP_W+PIDX_W]          = tier;
    gap = 0;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(0, 6);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = track_event(op, page, tier);
    outcome_queue.push_back(typed ? typed_want : predicted);
    events_sent++;
  endtask

  // hold off until every owed word is back, then let the pipeline settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (outcome_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers, one per cycle; only called with the block idle
  task automatic set_thresholds(logic [CFG_W-1:0] hot, logic [CFG_W-1:0] cool);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_HOT_THR;
    cfg_data  <= hot;
    @(posedge clk);
    cfg_index <= REG_COOL_THR;
    cfg_data  <= cool;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    hot_thr  = hot;
    cool_thr = cool;
    @(posedge clk);
  endtask

  // random mix over a small mapped working set so counters climb, requests
  // fire and epochs move; a slice is noise on random pages and reserved codes
  task automatic random_events(int count);
    logic [PIDX_W-1:0] working [$];
    logic [PIDX_W-1:0] pg;
    logic [OP_W-1:0]   op;
    int                k;
    int                i;
    int                pick;
    k = $urandom_range(4, 24);
    repeat (k) working.push_back(PIDX_W'($urandom_range(0, PAGES - 1)));
    working.push_back('0);
    working.push_back(PIDX_W'(PAGES - 1));
    foreach (working[j])
      send_event(OP_MAP, working[j], 1'($urandom_range(0, 1)), 1'b0, NO_OUTCOME);
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      pg   = working[$urandom_range(0, working.size() - 1)];
      if (pick < 62) begin
        op = OP_SAMPLE;
      end else if (pick < 70) begin
        op = OP_PROMOTE;
      end else if (pick < 78) begin
        op = OP_DEMOTE;
      end else if (pick < 84) begin
        op = OP_MAP;
      end else if (pick < 89) begin
        op = OP_UNMAP;
      end else if (pick < 95) begin
        op = OP_W'($urandom_range(OP_SAMPLE, OP_UNMAP));
        pg = PIDX_W'($urandom_range(0, PAGES - 1));
      end else begin
        op = OP_W'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
        pg = PIDX_W'($urandom_range(0, PAGES - 1));
      end
      send_event(op, pg, 1'($urandom_range(0, 1)), 1'b0, NO_OUTCOME);
      // now and then wait for the block to empty out completely
      if ($urandom_range(0, 79) == 0) drain_results();
    end
  endtask

  // directed table, run at the reset thresholds; typed rows are read off by
  // hand (untouched pages, reserved codes, first samples at epoch zero)
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{1'b1, IGNORED_AT_ZERO, OP_SAMPLE,             12'd0,    1'b0},  // sample of unmapped page
    '{1'b1, IGNORED_AT_ZERO, OP_PROMOTE,            12'd4095, 1'b1},  // completion, unmapped
    '{1'b1, IGNORED_AT_ZERO, OP_DEMOTE,             12'd4095, 1'b0},
    '{1'b1, APPLIED_AT_ZERO, OP_UNMAP,              12'd4095, 1'b1},  // unmap of unmapped page
    '{1'b1, APPLIED_AT_ZERO, OP_RESERVED_FIRST,     12'd7,    1'b0},  // reserved codes
    '{1'b1, APPLIED_AT_ZERO, OP_RESERVED_LAST,      12'd4095, 1'b1},
    '{1'b1, APPLIED_AT_ZERO, OP_W'(OP_RESERVED_FIRST + 1), 12'd2048, 1'b0},
    '{1'b1, APPLIED_AT_ZERO, OP_MAP,                12'd0,    1'b0},
    '{1'b1, APPLIED_AT_ZERO, OP_MAP,                12'd4095, 1'b1},
    '{1'b1, APPLIED_AT_ZERO, OP_SAMPLE,             12'd0,    1'b0},  // first read, below hot
    '{1'b1, APPLIED_AT_ZERO, OP_SAMPLE,             12'd4095, 1'b1},
    '{1'b0, NO_OUTCOME,      OP_PROMOTE,            12'd0,    1'b0},  // unsolicited completion
    '{1'b0, NO_OUTCOME,      OP_SAMPLE,             12'd0,    1'b1},  // hot but cold: demote
    '{1'b0, NO_OUTCOME,      OP_DEMOTE,             12'd0,    1'b0},
    '{1'b0, NO_OUTCOME,      OP_SAMPLE,             12'd4095, 1'b1},
    '{1'b0, NO_OUTCOME,      OP_UNMAP,              12'd0,    1'b0},  // clears a live page
    '{1'b1, IGNORED_AT_ZERO, OP_SAMPLE,             12'd0,    1'b0},
    '{1'b0, NO_OUTCOME,      OP_MAP,                12'd0,    1'b1},  // remap, counters zero
    '{1'b0, NO_OUTCOME,      OP_SAMPLE,             12'd0,    1'b0},
    '{1'b1, IGNORED_AT_ZERO, OP_SAMPLE,             12'd2048, 1'b1}
  };

  initial begin
    int r;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < DIRECTED_ROWS; r++)
      send_event(directed_rows[r].op, directed_rows[r].page, directed_rows[r].tier,
                 directed_rows[r].typed, directed_rows[r].want);
    drain_results();

    // lowest thresholds: a repeat read that missed no epoch advances the epoch,
    // pages left alone fall behind by whole counter widths and get cleared
    set_thresholds(16'd1, 16'd1);
    random_events(220);
    drain_results();

    // highest thresholds: a run of fast reads on one page with no gaps and
    // no stalls, then slow reads, a completion and more slow reads
    set_thresholds(16'hFFFF, 16'hFFFF);
    gaps_on   = 1'b0;
    rx_always = 1'b1;
    run_page  = $urandom_range(1, PAGES - 2);
    send_event(OP_MAP, PIDX_W'(run_page), 1'b0, 1'b0, NO_OUTCOME);
    repeat (RUN_READS) send_event(OP_SAMPLE, PIDX_W'(run_page), 1'b0, 1'b0, NO_OUTCOME);
    repeat (6) send_event(OP_SAMPLE, PIDX_W'(run_page), 1'b1, 1'b0, NO_OUTCOME);
    send_event(OP_PROMOTE, PIDX_W'(run_page), 1'b0, 1'b0, NO_OUTCOME);
    repeat (4) send_event(OP_SAMPLE, PIDX_W'(run_page), 1'b1, 1'b0, NO_OUTCOME);
    drain_results();
    gaps_on   = 1'b1;
    rx_always = 1'b0;

    // moderate settings, hot reachable and epochs moving at a middling pace
    set_thresholds(CFG_W'($urandom_range(2, 12)), CFG_W'($urandom_range(3, 20)));
    random_events(220);
    drain_results();

    set_thresholds(CFG_W'($urandom_range(1, 40)), CFG_W'($urandom_range(1, 40)));
    random_events(220);
    drain_results();

    $display("ran %0d events, checked %0d words: %0d promote and %0d demote requests",
             events_sent, results_seen, promotes_seen, demotes_seen);
    $display("epoch advanced %0d times to %0d; back-to-back read run on page %0d",
             advances_seen, cur_epoch, run_page);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/pht_pkg.sv
design/page_hotness_tracker_core.sv
bench/page_hotness_tracker_core_test.sv
